### rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion helpers with a clock and an active-low synchronous reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

### rtl/core/lnnm_pkg.sv
// ----------------------------------------------------------------------------
// lnnm_pkg
// Shared types and codes of the landmark nearest-neighbor matcher.
// ----------------------------------------------------------------------------
package lnnm_pkg;

  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_ROBOT_X   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ROBOT_Y   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAP_COUNT = 2'd2;

  localparam int MAP_COUNT_W = 7;
  localparam int INDEX_W     = 6;

  localparam logic KIND_LOAD  = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ISSUE,
    ST_WAIT
  } state_t;

  // tag that travels with each candidate through the scan pipeline
  typedef struct packed {
    logic vld;
    logic robot;  // candidate is the robot position (range reference)
    logic last;   // final candidate of this query
  } tag_t;

endpackage

### rtl/core/lnnm_store.sv
// ----------------------------------------------------------------------------
// lnnm_store
// Landmark store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module lnnm_store #(
  parameter int DEPTH = 64,
  parameter int AW    = 6,
  parameter int DW    = 32
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### rtl/core/lnnm_scan.sv
// ----------------------------------------------------------------------------
// lnnm_scan
// Distance pipeline: square stage, running-minimum stage, gate and result.
// ----------------------------------------------------------------------------
module lnnm_scan #(
  parameter int COORD_BITS = 16,
  parameter int AW         = 6
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  lnnm_pkg::tag_t                      tag_i,
  input  logic [AW-1:0]                       idx_i,
  input  logic signed [COORD_BITS-1:0]        mem_x_i,
  input  logic signed [COORD_BITS-1:0]        mem_y_i,
  input  logic signed [COORD_BITS-1:0]        robot_x_i,
  input  logic signed [COORD_BITS-1:0]        robot_y_i,
  input  logic signed [COORD_BITS-1:0]        pt_x_i,
  input  logic signed [COORD_BITS-1:0]        pt_y_i,
  output logic                                res_vld_o,
  output logic                                matched_o,
  output logic [lnnm_pkg::INDEX_W-1:0]        index_o,
  output logic signed [COORD_BITS:0]          innov_x_o,
  output logic signed [COORD_BITS:0]          innov_y_o
);

  localparam int DW  = COORD_BITS + 1;
  localparam int SQW = 2 * COORD_BITS;
  localparam int DSW = SQW + 1;
  localparam int HW  = DSW + 7;

  // square stage
  logic signed [COORD_BITS-1:0] cand_x, cand_y;
  logic signed [DW-1:0]         dx, dy;
  logic signed [2*DW-1:0]       sqx_full, sqy_full;

  lnnm_pkg::tag_t               s1_tag_r;
  logic [AW-1:0]                s1_idx_r;
  logic signed [DW-1:0]         s1_dx_r, s1_dy_r;
  logic [SQW-1:0]               s1_sqx_r, s1_sqy_r;

  // running minimum
  logic [DSW-1:0]               dsum;
  logic                         better;
  logic                         have_r;
  logic [DSW-1:0]               best_d_r, r2_r;
  logic [AW-1:0]                best_idx_r;
  logic signed [DW-1:0]         best_dx_r, best_dy_r;
  logic                         s2_fin_r;

  // gate
  logic                         g1_vld_r;
  logic [HW-1:0]                hund_r;
  logic                         hit;

  logic                         out_vld_r, matched_r;
  logic [lnnm_pkg::INDEX_W-1:0] index_r;
  logic signed [DW-1:0]         innov_x_r, innov_y_r;

  assign cand_x   = tag_i.robot ? robot_x_i : mem_x_i;
  assign cand_y   = tag_i.robot ? robot_y_i : mem_y_i;
  // landmark minus query; also the innovation
  assign dx       = DW'(cand_x) - DW'(pt_x_i);
  assign dy       = DW'(cand_y) - DW'(pt_y_i);
  assign sqx_full = dx * dx;
  assign sqy_full = dy * dy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_tag_r <= '0;
    end else begin
      s1_tag_r <= tag_i;
    end
  end

  always_ff @(posedge clk) begin
    s1_idx_r <= idx_i;
    s1_dx_r  <= dx;
    s1_dy_r  <= dy;
    s1_sqx_r <= sqx_full[SQW-1:0];
    s1_sqy_r <= sqy_full[SQW-1:0];
  end

  assign dsum   = DSW'(s1_sqx_r) + DSW'(s1_sqy_r);
  // strict less-than keeps the lowest index on ties
  assign better = !have_r || (dsum < best_d_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      have_r   <= 1'b0;
      s2_fin_r <= 1'b0;
    end else begin
      s2_fin_r <= s1_tag_r.vld && s1_tag_r.last;
      if (s1_tag_r.vld) begin
        if (s1_tag_r.robot) begin
          have_r <= 1'b0;
        end else if (better) begin
          have_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_tag_r.vld) begin
      if (s1_tag_r.robot) begin
        r2_r <= dsum;
      end else if (better) begin
        best_d_r   <= dsum;
        best_idx_r <= s1_idx_r;
        best_dx_r  <= s1_dx_r;
        best_dy_r  <= s1_dy_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      g1_vld_r <= 1'b0;
    end else begin
      g1_vld_r <= s2_fin_r;
    end
  end

  always_ff @(posedge clk) begin
    hund_r <= HW'(best_d_r) * HW'(100);
  end

  assign hit = have_r && (hund_r < HW'(r2_r));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else begin
      out_vld_r <= g1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (g1_vld_r) begin
      matched_r <= hit;
      index_r   <= hit ? lnnm_pkg::INDEX_W'(best_idx_r) : '0;
      innov_x_r <= hit ? best_dx_r : '0;
      innov_y_r <= hit ? best_dy_r : '0;
    end
  end

  assign res_vld_o = out_vld_r;
  assign matched_o = matched_r;
  assign index_o   = index_r;
  assign innov_x_o = innov_x_r;
  assign innov_y_o = innov_y_r;

endmodule

### rtl/core/landmark_nearest_neighbor_matcher.sv
// ----------------------------------------------------------------------------
// landmark_nearest_neighbor_matcher
// Nearest stored landmark search with a range-relative distance gate.
// ----------------------------------------------------------------------------
// A load item (kind 0) writes one landmark into the store and busy stays
// low. A query item (kind 1) raises busy and scans store entries
// 0 .. map_count-1 (clipped to MAP_DEPTH), one store read per cycle, then
// one result strobe appears on out_valid. Between acceptance of a query and
// the earliest next item lie one read per landmark plus the robot range
// pass and the square, minimum, gate and output stages. The result is shown
// for one cycle only and cannot be held off, so the receiver must take it
// when out_valid is high. Loads and scans never overlap, so no store entry
// is read and written in the same cycle. Landmarks read by a query must have
// been loaded first.
// ----------------------------------------------------------------------------
module landmark_nearest_neighbor_matcher #(
  parameter int MAP_DEPTH  = 64,
  parameter int COORD_BITS = 16
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  // configuration
  input  logic                                  cfg_we,
  input  logic [lnnm_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [COORD_BITS-1:0]                 cfg_data,
  // input items
  input  logic                                  start,
  output logic                                  busy,
  input  logic                                  in_kind,
  input  logic [lnnm_pkg::INDEX_W-1:0]          in_slot,
  input  logic signed [COORD_BITS-1:0]          in_point_x,
  input  logic signed [COORD_BITS-1:0]          in_point_y,
  input  logic                                  in_query_last,
  // results
  output logic                                  out_valid,
  output logic                                  out_matched,
  output logic [lnnm_pkg::INDEX_W-1:0]          out_match_index,
  output logic signed [COORD_BITS:0]            out_innov_x,
  output logic signed [COORD_BITS:0]            out_innov_y,
  output logic                                  out_batch_end
);

  `include "assert_macros.svh"

  localparam int AW    = (MAP_DEPTH > 1) ? $clog2(MAP_DEPTH) : 1;
  localparam int CNT_W = $clog2(MAP_DEPTH + 1);
  localparam int MW    = 2 * COORD_BITS;

  // configuration registers
  logic signed [COORD_BITS-1:0]            robot_x_r, robot_y_r;
  logic [lnnm_pkg::MAP_COUNT_W-1:0]        map_count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      robot_x_r   <= '0;
      robot_y_r   <= '0;
      map_count_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        lnnm_pkg::CFG_ROBOT_X:   robot_x_r   <= cfg_data;
        lnnm_pkg::CFG_ROBOT_Y:   robot_y_r   <= cfg_data;
        lnnm_pkg::CFG_MAP_COUNT: map_count_r <= cfg_data[lnnm_pkg::MAP_COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  // control
  lnnm_pkg::state_t state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [CNT_W-1:0] lim_r, lim_nxt;
  logic [CNT_W-1:0] count_eff;
  lnnm_pkg::tag_t   rd_tag_r, rd_tag_nxt;
  logic [AW-1:0]    rd_idx_r;
  logic             accept, mem_we, mem_re, res_vld;
  logic signed [COORD_BITS-1:0] px_r, py_r;
  logic             last_r;
  logic [MW-1:0]    mem_q;

  assign accept    = start && !busy;
  assign count_eff = (32'(map_count_r) > MAP_DEPTH) ? CNT_W'(MAP_DEPTH)
                                                     : CNT_W'(map_count_r);
  assign mem_we    = accept && (in_kind == lnnm_pkg::KIND_LOAD)
                     && (32'(in_slot) < MAP_DEPTH);

  always_comb begin
    state_nxt  = state_r;
    cnt_nxt    = cnt_r;
    lim_nxt    = lim_r;
    rd_tag_nxt = '0;
    mem_re     = 1'b0;
    busy       = (state_r != lnnm_pkg::ST_IDLE);
    case (state_r)
      lnnm_pkg::ST_IDLE: begin
        if (start && (in_kind == lnnm_pkg::KIND_QUERY)) begin
          // robot position goes first to give the range reference
          rd_tag_nxt.vld   = 1'b1;
          rd_tag_nxt.robot = 1'b1;
          rd_tag_nxt.last  = (count_eff == '0);
          cnt_nxt          = '0;
          lim_nxt          = count_eff;
          state_nxt        = (count_eff == '0) ? lnnm_pkg::ST_WAIT : lnnm_pkg::ST_ISSUE;
        end
      end
      lnnm_pkg::ST_ISSUE: begin
        mem_re          = 1'b1;
        rd_tag_nxt.vld  = 1'b1;
        rd_tag_nxt.last = (CNT_W'(cnt_r + 1'b1) == lim_r);
        cnt_nxt         = CNT_W'(cnt_r + 1'b1);
        if (rd_tag_nxt.last) begin
          state_nxt = lnnm_pkg::ST_WAIT;
        end
      end
      lnnm_pkg::ST_WAIT: begin
        if (res_vld) begin
          state_nxt = lnnm_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = lnnm_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= lnnm_pkg::ST_IDLE;
      cnt_r    <= '0;
      lim_r    <= '0;
      rd_tag_r <= '0;
    end else begin
      state_r  <= state_nxt;
      cnt_r    <= cnt_nxt;
      lim_r    <= lim_nxt;
      rd_tag_r <= rd_tag_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rd_idx_r <= cnt_r[AW-1:0];
    if (accept && (in_kind == lnnm_pkg::KIND_QUERY)) begin
      px_r   <= in_point_x;
      py_r   <= in_point_y;
      last_r <= in_query_last;
    end
  end

  lnnm_store #(
    .DEPTH (MAP_DEPTH),
    .AW    (AW),
    .DW    (MW)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (AW'(in_slot)),
    .wdata ({in_point_x, in_point_y}),
    .re    (mem_re),
    .raddr (cnt_r[AW-1:0]),
    .rdata (mem_q)
  );

  lnnm_scan #(
    .COORD_BITS (COORD_BITS),
    .AW         (AW)
  ) u_scan (
    .clk       (clk),
    .rst_n     (rst_n),
    .tag_i     (rd_tag_r),
    .idx_i     (rd_idx_r),
    .mem_x_i   (mem_q[MW-1:COORD_BITS]),
    .mem_y_i   (mem_q[COORD_BITS-1:0]),
    .robot_x_i (robot_x_r),
    .robot_y_i (robot_y_r),
    .pt_x_i    (px_r),
    .pt_y_i    (py_r),
    .res_vld_o (res_vld),
    .matched_o (out_matched),
    .index_o   (out_match_index),
    .innov_x_o (out_innov_x),
    .innov_y_o (out_innov_y)
  );

  assign out_valid     = res_vld;
  assign out_batch_end = last_r;

  `ASSERT_IMPLY(a_result_while_busy, clk, rst_n, out_valid, state_r == lnnm_pkg::ST_WAIT)
  `ASSERT_IMPLY(a_scan_in_range, clk, rst_n, state_r == lnnm_pkg::ST_ISSUE, cnt_r < lim_r)
  `ASSERT_NEXT(a_query_busy, clk, rst_n, accept && (in_kind == lnnm_pkg::KIND_QUERY), busy)
  `ASSERT_IMPLY(a_no_write_in_scan, clk, rst_n, mem_re, !mem_we)

endmodule

### dv/nn_match_checker.sv
// ----------------------------------------------------------------------------
// nn_match_checker
// Watches the matcher's ports, predicts each query result and compares it.
// ----------------------------------------------------------------------------
// Keeps its own copy of the landmark store and of the robot/map_count
// registers. Every accepted query pushes one predicted result; every result
// strobe is compared field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module nn_match_checker #(
  parameter int MAP_DEPTH  = 64,
  parameter int COORD_BITS = 16
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  cfg_we,
  input  logic [lnnm_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [COORD_BITS-1:0]                 cfg_data,
  input  logic                                  start,
  input  logic                                  busy,
  input  logic                                  in_kind,
  input  logic [lnnm_pkg::INDEX_W-1:0]          in_slot,
  input  logic signed [COORD_BITS-1:0]          in_point_x,
  input  logic signed [COORD_BITS-1:0]          in_point_y,
  input  logic                                  in_query_last,
  input  logic                                  out_valid,
  input  logic                                  out_matched,
  input  logic [lnnm_pkg::INDEX_W-1:0]          out_match_index,
  input  logic signed [COORD_BITS:0]            out_innov_x,
  input  logic signed [COORD_BITS:0]            out_innov_y,
  input  logic                                  out_batch_end,
  output int                                    mismatches,
  output int                                    awaited,
  output int                                    traffic
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic                               matched;
    logic [lnnm_pkg::INDEX_W-1:0]       index;
    logic signed [COORD_BITS:0]         innov_x;
    logic signed [COORD_BITS:0]         innov_y;
    logic                               batch_end;
  } match_t;

  localparam int NO_CANDIDATE = -1;

  logic signed [COORD_BITS-1:0]         lm_x [MAP_DEPTH];
  logic signed [COORD_BITS-1:0]         lm_y [MAP_DEPTH];
  logic signed [COORD_BITS-1:0]         robot_x;
  logic signed [COORD_BITS-1:0]         robot_y;
  logic [lnnm_pkg::MAP_COUNT_W-1:0]     map_count;

  match_t expected_matches [$];

  function automatic longint sq_range(input longint ax, input longint ay,
                                      input longint bx, input longint by);
    longint dx;
    longint dy;
    dx = ax - bx;
    dy = ay - by;
    return dx * dx + dy * dy;
  endfunction

  function automatic match_t predict_match(input logic signed [COORD_BITS-1:0] px,
                                           input logic signed [COORD_BITS-1:0] py,
                                           input logic last);
    match_t m;
    int     n;
    int     j;
    int     best;
    longint best_d;
    longint d;
    longint r2;
    longint ix;
    longint iy;
    n = (map_count > MAP_DEPTH) ? MAP_DEPTH : int'(map_count);
    best = NO_CANDIDATE;
    best_d = 0;
    for (j = 0; j < n; j++) begin
      d = sq_range(px, py, lm_x[j], lm_y[j]);
      // strict compare keeps the lowest index on ties
      if (best == NO_CANDIDATE || d < best_d) begin
        best = j;
        best_d = d;
      end
    end
    r2 = sq_range(px, py, robot_x, robot_y);
    m = '0;
    m.batch_end = last;
    if (best != NO_CANDIDATE && best_d * 100 < r2) begin
      ix = longint'(lm_x[best]) - longint'(px);
      iy = longint'(lm_y[best]) - longint'(py);
      m.matched = 1'b1;
      m.index   = best[lnnm_pkg::INDEX_W-1:0];
      m.innov_x = ix[COORD_BITS:0];
      m.innov_y = iy[COORD_BITS:0];
    end
    return m;
  endfunction

  task automatic check_field(input string what, input logic signed [63:0] want,
                             input logic signed [63:0] got);
    if (want !== got) begin
      mismatches++;
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, what, want, got);
    end
  endtask

  always @(posedge clk) begin
    match_t exp_m;
    if (!rst_n) begin
      robot_x    = '0;
      robot_y    = '0;
      map_count  = '0;
      mismatches = 0;
      traffic    = 0;
      expected_matches.delete();
      awaited    = 0;
    end else begin
      if (out_valid) begin
        traffic++;
        if (expected_matches.size() == 0) begin
          mismatches++;
          $display("%0t: result with no query outstanding: matched %0b index %0d",
                   $time, out_matched, out_match_index);
        end else begin
          exp_m = expected_matches.pop_front();
          check_field("matched", exp_m.matched, out_matched);
          check_field("match_index", exp_m.index, out_match_index);
          check_field("innov_x", exp_m.innov_x, out_innov_x);
          check_field("innov_y", exp_m.innov_y, out_innov_y);
          check_field("batch_end", exp_m.batch_end, out_batch_end);
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          lnnm_pkg::CFG_ROBOT_X:   robot_x = cfg_data;
          lnnm_pkg::CFG_ROBOT_Y:   robot_y = cfg_data;
          lnnm_pkg::CFG_MAP_COUNT: map_count = cfg_data[lnnm_pkg::MAP_COUNT_W-1:0];
          default: ;
        endcase
      end
      if (start && !busy) begin
        traffic++;
        if (in_kind == lnnm_pkg::KIND_LOAD) begin
          if (in_slot < MAP_DEPTH) begin
            lm_x[in_slot] = in_point_x;
            lm_y[in_slot] = in_point_y;
          end
        end else begin
          expected_matches.push_back(predict_match(in_point_x, in_point_y, in_query_last));
        end
      end
      awaited = expected_matches.size();
    end
  end

endmodule

### dv/tb_landmark_nearest_neighbor_matcher.sv
// ----------------------------------------------------------------------------
// tb_landmark_nearest_neighbor_matcher
// Stimulus and verdict for the landmark nearest-neighbor matcher.
// ----------------------------------------------------------------------------
// A short directed run covers empty map, ties, zero range, the gate boundary
// and coordinate extremes; then the store is filled and random phases follow,
// each with fresh robot/map_count settings and a mix of loads and queries
// (about half aimed near stored landmarks so the gate can pass). Checking is
// done by nn_match_checker; a watchdog ends the run if traffic stops.
// ----------------------------------------------------------------------------
module tb_landmark_nearest_neighbor_matcher;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAP_DEPTH      = 64;
  localparam int COORD_BITS     = 16;
  localparam int NUM_PHASES     = 21;
  localparam int PHASE_ITEMS    = 64;
  localparam int SETTLE_CYCLES  = 8;
  localparam int DRAIN_CYCLES   = MAP_DEPTH + 16;
  localparam int WATCHDOG_LIMIT = 2000;

  localparam logic [lnnm_pkg::CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

  localparam logic signed [COORD_BITS-1:0] C_MIN = {1'b1, {(COORD_BITS-1){1'b0}}};
  localparam logic signed [COORD_BITS-1:0] C_MAX = {1'b0, {(COORD_BITS-1){1'b1}}};

  logic                               clk = 1'b0;
  logic                               rst_n;
  logic                               cfg_we;
  logic [lnnm_pkg::CFG_IDX_W-1:0]     cfg_index;
  logic [COORD_BITS-1:0]              cfg_data;
  logic                               start;
  logic                               busy;
  logic                               in_kind;
  logic [lnnm_pkg::INDEX_W-1:0]       in_slot;
  logic signed [COORD_BITS-1:0]       in_point_x;
  logic signed [COORD_BITS-1:0]       in_point_y;
  logic                               in_query_last;
  logic                               out_valid;
  logic                               out_matched;
  logic [lnnm_pkg::INDEX_W-1:0]       out_match_index;
  logic signed [COORD_BITS:0]         out_innov_x;
  logic signed [COORD_BITS:0]         out_innov_y;
  logic                               out_batch_end;

  int mismatches;
  int awaited;
  int traffic;

  // stimulus bookkeeping only, used to aim queries
  logic signed [COORD_BITS-1:0]       lm_x [MAP_DEPTH];
  logic signed [COORD_BITS-1:0]       lm_y [MAP_DEPTH];
  logic signed [COORD_BITS-1:0]       rob_x;
  logic signed [COORD_BITS-1:0]       rob_y;
  logic [lnnm_pkg::MAP_COUNT_W-1:0]   search_cnt;
  int                                 idle_pct;

  int last_traffic = 0;
  int stall_cycles = 0;

  always #5 clk = ~clk;

  landmark_nearest_neighbor_matcher #(
    .MAP_DEPTH  (MAP_DEPTH),
    .COORD_BITS (COORD_BITS)
  ) DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .start           (start),
    .busy            (busy),
    .in_kind         (in_kind),
    .in_slot         (in_slot),
    .in_point_x      (in_point_x),
    .in_point_y      (in_point_y),
    .in_query_last   (in_query_last),
    .out_valid       (out_valid),
    .out_matched     (out_matched),
    .out_match_index (out_match_index),
    .out_innov_x     (out_innov_x),
    .out_innov_y     (out_innov_y),
    .out_batch_end   (out_batch_end)
  );

  nn_match_checker #(
    .MAP_DEPTH  (MAP_DEPTH),
    .COORD_BITS (COORD_BITS)
  ) match_check (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .start           (start),
    .busy            (busy),
    .in_kind         (in_kind),
    .in_slot         (in_slot),
    .in_point_x      (in_point_x),
    .in_point_y      (in_point_y),
    .in_query_last   (in_query_last),
    .out_valid       (out_valid),
    .out_matched     (out_matched),
    .out_match_index (out_match_index),
    .out_innov_x     (out_innov_x),
    .out_innov_y     (out_innov_y),
    .out_batch_end   (out_batch_end),
    .mismatches      (mismatches),
    .awaited         (awaited),
    .traffic         (traffic)
  );

  // no item and no result for too long
  always @(negedge clk) begin
    if (!rst_n || traffic != last_traffic) begin
      last_traffic <= traffic;
      stall_cycles <= 0;
    end else if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: watchdog, no traffic for %0d cycles", $time, stall_cycles);
      $display("Regression FAIL");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  function automatic logic signed [COORD_BITS-1:0] pick_coord();
    case ($urandom_range(0, 9))
      0:       return C_MIN;
      1:       return C_MAX;
      default: return COORD_BITS'($urandom());
    endcase
  endfunction

  // small, medium or wide offset; wraps at the coordinate width
  function automatic logic signed [COORD_BITS-1:0] nudge(
      input logic signed [COORD_BITS-1:0] c);
    int off;
    case ($urandom_range(0, 2))
      0:       begin off = $urandom_range(0, 6);    off -= 3;    end
      1:       begin off = $urandom_range(0, 510);  off -= 255;  end
      default: begin off = $urandom_range(0, 8190); off -= 4095; end
    endcase
    return COORD_BITS'(int'(c) + off);
  endfunction

  // start is low and the fields carry noise while idle
  task automatic idle_gap(input int n);
    start         <= 1'b0;
    in_kind       <= 1'($urandom());
    in_slot       <= lnnm_pkg::INDEX_W'($urandom());
    in_point_x    <= COORD_BITS'($urandom());
    in_point_y    <= COORD_BITS'($urandom());
    in_query_last <= 1'($urandom());
    repeat (n) @(negedge clk);
  endtask

  task automatic put_item(input logic kind, input logic [lnnm_pkg::INDEX_W-1:0] slot,
                          input logic signed [COORD_BITS-1:0] px,
                          input logic signed [COORD_BITS-1:0] py,
                          input logic last);
    start         <= 1'b1;
    in_kind       <= kind;
    in_slot       <= slot;
    in_point_x    <= px;
    in_point_y    <= py;
    in_query_last <= last;
    if (kind == lnnm_pkg::KIND_LOAD) begin
      lm_x[slot] = px;
      lm_y[slot] = py;
    end
    // busy is stable between edges, so this decides the next edge
    while (busy) @(negedge clk);
    @(negedge clk);
    if ($urandom_range(0, 99) < idle_pct) idle_gap($urandom_range(1, 7));
  endtask

  task automatic write_reg(input logic [lnnm_pkg::CFG_IDX_W-1:0] idx,
                           input logic [COORD_BITS-1:0] d);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    @(negedge clk);
  endtask

  // only while idle: all results in, then a settle period
  task automatic configure(input logic signed [COORD_BITS-1:0] rx,
                           input logic signed [COORD_BITS-1:0] ry,
                           input logic [lnnm_pkg::MAP_COUNT_W-1:0] mc, input bit noisy);
    logic [COORD_BITS-1:0] mc_word;
    start <= 1'b0;
    while (awaited != 0 || busy) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    mc_word = '0;
    if (noisy && $urandom_range(0, 3) == 0) mc_word = COORD_BITS'($urandom());
    mc_word[lnnm_pkg::MAP_COUNT_W-1:0] = mc;
    write_reg(lnnm_pkg::CFG_ROBOT_X, rx);
    write_reg(lnnm_pkg::CFG_ROBOT_Y, ry);
    write_reg(lnnm_pkg::CFG_MAP_COUNT, mc_word);
    if (noisy && $urandom_range(0, 9) == 0) write_reg(CFG_UNUSED, COORD_BITS'($urandom()));
    cfg_we <= 1'b0;
    @(negedge clk);
    rob_x = rx;
    rob_y = ry;
    search_cnt = mc;
  endtask

  task automatic random_load();
    int s;
    int src;
    logic signed [COORD_BITS-1:0] lx;
    logic signed [COORD_BITS-1:0] ly;
    s   = $urandom_range(0, MAP_DEPTH-1);
    src = $urandom_range(0, MAP_DEPTH-1);
    case ($urandom_range(0, 3))
      0:       begin lx = lm_x[src];        ly = lm_y[src];        end  // duplicate, ties
      1:       begin lx = nudge(lm_x[src]); ly = nudge(lm_y[src]); end
      default: begin lx = pick_coord();     ly = pick_coord();     end
    endcase
    put_item(lnnm_pkg::KIND_LOAD, s[lnnm_pkg::INDEX_W-1:0], lx, ly, 1'($urandom()));
  endtask

  task automatic random_query();
    int n;
    int j;
    int r;
    logic signed [COORD_BITS-1:0] qx;
    logic signed [COORD_BITS-1:0] qy;
    n = (search_cnt > MAP_DEPTH) ? MAP_DEPTH : int'(search_cnt);
    r = $urandom_range(0, 99);
    if (r < 50 && n > 0) begin
      j  = $urandom_range(0, n-1);
      qx = nudge(lm_x[j]);
      qy = nudge(lm_y[j]);
    end else if (r < 65) begin
      qx = rob_x;
      qy = rob_y;
    end else if (r < 75) begin
      qx = nudge(rob_x);
      qy = nudge(rob_y);
    end else begin
      qx = pick_coord();
      qy = pick_coord();
    end
    put_item(lnnm_pkg::KIND_QUERY, lnnm_pkg::INDEX_W'($urandom()), qx, qy,
             ($urandom_range(0, 3) == 0));
  endtask

  initial begin
    int ph;
    int k;
    logic [lnnm_pkg::MAP_COUNT_W-1:0] mc;
    logic signed [COORD_BITS-1:0] rx;
    logic signed [COORD_BITS-1:0] ry;

    rst_n         = 1'b0;
    cfg_we        = 1'b0;
    cfg_index     = lnnm_pkg::CFG_ROBOT_X;
    cfg_data      = '0;
    start         = 1'b0;
    in_kind       = lnnm_pkg::KIND_LOAD;
    in_slot       = '0;
    in_point_x    = '0;
    in_point_y    = '0;
    in_query_last = 1'b0;
    rob_x         = '0;
    rob_y         = '0;
    search_cnt    = '0;
    idle_pct      = 30;

    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: registers at reset value, empty map
    put_item(lnnm_pkg::KIND_QUERY, 6'd0, 16'sd100, 16'sd200, 1'b1);
    put_item(lnnm_pkg::KIND_LOAD, 6'd0, C_MAX, C_MAX, 1'b0);
    put_item(lnnm_pkg::KIND_LOAD, 6'd1, C_MIN, C_MIN, 1'b0);
    put_item(lnnm_pkg::KIND_LOAD, 6'd2, 16'sd1000, -16'sd1000, 1'b0);
    put_item(lnnm_pkg::KIND_LOAD, 6'd3, 16'sd1000, -16'sd1000, 1'b1);

    configure(C_MIN, C_MIN, 7'd4, 1'b0);
    put_item(lnnm_pkg::KIND_QUERY, 6'd63, C_MAX, C_MAX - 16'sd1, 1'b0);
    put_item(lnnm_pkg::KIND_QUERY, 6'd0, 16'sd1003, -16'sd998, 1'b1);  // tie on slots 2 and 3
    put_item(lnnm_pkg::KIND_QUERY, 6'd0, C_MIN, C_MIN, 1'b0);          // at the robot
    put_item(lnnm_pkg::KIND_QUERY, 6'd0, C_MIN, C_MIN + 16'sd1, 1'b1); // d2 equals r2

    configure(C_MAX, C_MAX, 7'd4, 1'b0);
    put_item(lnnm_pkg::KIND_QUERY, 6'd0, C_MIN, C_MIN, 1'b0);
    put_item(lnnm_pkg::KIND_QUERY, 6'd0, C_MAX, C_MAX, 1'b1);

    // gate boundary: 100*d2 == r2 fails, one step closer passes
    configure('0, '0, 7'd5, 1'b0);
    put_item(lnnm_pkg::KIND_LOAD, 6'd4, 16'sd90, 16'sd0, 1'b0);
    put_item(lnnm_pkg::KIND_QUERY, 6'd0, 16'sd100, 16'sd0, 1'b0);
    put_item(lnnm_pkg::KIND_LOAD, 6'd4, 16'sd91, 16'sd0, 1'b0);
    put_item(lnnm_pkg::KIND_QUERY, 6'd0, 16'sd100, 16'sd0, 1'b1);
    put_item(lnnm_pkg::KIND_LOAD, 6'd63, -16'sd1, 16'sd1, 1'b1);

    configure('0, '0, 7'd0, 1'b0);
    put_item(lnnm_pkg::KIND_QUERY, 6'd0, 16'sd5, 16'sd5, 1'b0);

    // fill the whole store so any map_count is legal from here on
    for (k = 0; k < MAP_DEPTH; k++) begin
      put_item(lnnm_pkg::KIND_LOAD, k[lnnm_pkg::INDEX_W-1:0], pick_coord(), pick_coord(),
               1'($urandom()));
    end

    for (ph = 0; ph < NUM_PHASES; ph++) begin
      if (ph >= NUM_PHASES - 2 || ph % 4 == 1) idle_pct = 0;
      else if (ph % 4 == 3) idle_pct = 60;
      else idle_pct = 30;

      if (ph == 0) begin
        rx = C_MAX;
        ry = C_MIN;
        mc = {lnnm_pkg::MAP_COUNT_W{1'b1}};
      end else begin
        if ($urandom_range(0, 99) < 15) begin
          rx = pick_coord();
          ry = pick_coord();
        end else begin
          rx = COORD_BITS'($urandom());
          ry = COORD_BITS'($urandom());
        end
        if (ph == 1) mc = 7'd1;
        else begin
          case ($urandom_range(0, 9))
            0:       mc = '0;
            1:       mc = lnnm_pkg::MAP_COUNT_W'(MAP_DEPTH);
            2:       mc = lnnm_pkg::MAP_COUNT_W'($urandom_range(MAP_DEPTH + 1,
                                                   (1 << lnnm_pkg::MAP_COUNT_W) - 1));
            3:       mc = lnnm_pkg::MAP_COUNT_W'($urandom_range(17, MAP_DEPTH - 1));
            default: mc = lnnm_pkg::MAP_COUNT_W'($urandom_range(1, 16));
          endcase
        end
      end
      configure(rx, ry, mc, 1'b1);

      for (k = 0; k < PHASE_ITEMS; k++) begin
        if ($urandom_range(0, 99) < 25) random_load();
        else random_query();
      end
    end

    start <= 1'b0;
    while (awaited != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    if (mismatches == 0 && awaited == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
